@@ rtl/core/fwpr_pkg.sv @@
// Shared types, widths and operation codes for the priority-removal queue.
package fwpr_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int KIND_W    = 2;
	localparam int PAY_W     = 16;
	localparam int PRI_W     = 8;
	localparam int CNT_OUT_W = 5;

	typedef logic [KIND_W-1:0]    kind_t;
	typedef logic [PAY_W-1:0]     pay_t;
	typedef logic [PRI_W-1:0]     pri_t;
	typedef logic [CNT_OUT_W-1:0] cnt_out_t;

	typedef struct packed {
		pri_t pri;
		pay_t pay;
	} entry_t;

	localparam kind_t KIND_PUSH       = kind_t'(0);
	localparam kind_t KIND_POP        = kind_t'(1);
	localparam kind_t KIND_REMOVE_MAX = kind_t'(2);

endpackage

@@ rtl/core/fwpr_if.sv @@
// Request and response channel interfaces of the priority-removal queue.
interface fwpr_req_if;
	import fwpr_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	pay_t  payload;
	pri_t  priority_req;

	modport source (output valid, output kind, output payload, output priority_req,
		input ready);
	modport sink (input valid, input kind, input payload, input priority_req,
		output ready);
endinterface

interface fwpr_rsp_if;
	import fwpr_pkg::*;

	logic     valid;
	logic     ready;
	pay_t     out_payload;
	logic     found;
	cnt_out_t count;
	logic     dropped;

	modport source (output valid, output out_payload, output found, output count,
		output dropped, input ready);
	modport sink (input valid, input out_payload, input found, input count,
		input dropped, output ready);
endinterface

@@ rtl/core/fwpr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fwpr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/core/fifo_with_priority_removal.sv @@
// Top level of the ordered queue with head pop and highest-priority removal.
//
// The req channel carries one operation per transfer: push (payload and
// priority appended at the tail), pop (head entry removed) or remove-max
// (entry of highest priority removed, the one nearest the head on a tie).
// The rsp channel returns exactly one result per operation: the removed
// payload, a found flag, the entry count after the operation and a dropped
// flag for a push into a full queue.
// Entries live in one RAM with a single read and a single write port; a
// sequencer walks that read port once to find the entry, then again to move
// every later entry down one place. A push or any operation on an empty
// queue skips both walks and goes straight to the result. req is not ready
// until the previous operation has put its result in the output register.
// Reset empties the queue and drops any pending result. When rsp stalls the
// result holds in the output register; the next operation may still be
// taken and worked, and waits at its end for the register to free up.
module fifo_with_priority_removal #(
	parameter int DEPTH = fwpr_pkg::DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fwpr_req_if.sink   req,
	fwpr_rsp_if.source rsp
);
	import fwpr_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_LAST  = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;
	logic [AW-1:0] scan_end_q;
	logic          v_s1;
	logic [AW-1:0] idx_s1;
	entry_t        best_q;
	logic [AW-1:0] best_idx_q;
	pay_t          res_pay_q;
	logic          res_found_q;
	logic          res_drop_q;
	logic          rsp_valid_q;

	logic                    accept;
	logic                    full;
	logic                    out_free;
	logic                    upd;
	logic [AW-1:0]           nb_idx;
	entry_t                  nb;
	entry_t                  rd;
	logic [$bits(entry_t)-1:0] rdata;
	logic                    we;
	logic [AW-1:0]           waddr;
	entry_t                  wdata;
	logic [AW-1:0]           raddr;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (cnt_q == CW'(DEPTH));
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign rd        = entry_t'(rdata);
	assign raddr     = ptr_q[AW-1:0];
	assign cnt_ext   = {CNT_OUT_W'(0), cnt_q};
	assign rsp.valid = rsp_valid_q;

	always_comb begin
		upd    = v_s1 && ((idx_s1 == '0) || (rd.pri > best_q.pri));
		nb_idx = upd ? idx_s1 : best_idx_q;
		nb     = upd ? rd : best_q;
	end

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = '{pri: req.priority_req, pay: req.payload};
		if (state_q == ST_IDLE) begin
			we = accept && (req.kind == KIND_PUSH) && !full;
		end else if (state_q == ST_SHIFT) begin
			we    = v_s1;
			waddr = idx_s1 - AW'(1);
			wdata = rd;
		end
	end

	fwpr_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_RESP) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			v_s1        <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ptr_q <= '0;
						v_s1  <= 1'b0;
						if (req.kind == KIND_PUSH) begin
							if (!full) begin
								cnt_q <= cnt_q + CW'(1);
							end
							state_q <= ST_RESP;
						end else if ((req.kind == KIND_POP || req.kind == KIND_REMOVE_MAX)
								&& cnt_q != '0) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_SCAN: begin
					v_s1 <= 1'b1;
					if (ptr_q[AW-1:0] == scan_end_q) begin
						state_q <= ST_LAST;
					end else begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				ST_LAST: begin
					v_s1    <= 1'b0;
					ptr_q   <= CW'(nb_idx) + CW'(1);
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (ptr_q < cnt_q) begin
						v_s1  <= 1'b1;
						ptr_q <= ptr_q + CW'(1);
					end else begin
						v_s1    <= 1'b0;
						cnt_q   <= cnt_q - CW'(1);
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_pay_q   <= '0;
					res_found_q <= 1'b0;
					res_drop_q  <= (req.kind == KIND_PUSH) && full;
					scan_end_q  <= (req.kind == KIND_POP) ? '0 : AW'(cnt_q - CW'(1));
				end
			end
			ST_SCAN: begin
				idx_s1 <= ptr_q[AW-1:0];
				if (v_s1) begin
					best_q     <= nb;
					best_idx_q <= nb_idx;
				end
			end
			ST_LAST: begin
				best_q     <= nb;
				best_idx_q <= nb_idx;
				res_pay_q  <= nb.pay;
			end
			ST_SHIFT: begin
				idx_s1 <= ptr_q[AW-1:0];
				if (!(ptr_q < cnt_q)) begin
					res_found_q <= 1'b1;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					rsp.out_payload <= res_pay_q;
					rsp.found       <= res_found_q;
					rsp.count       <= cnt_ext[CNT_OUT_W-1:0];
					rsp.dropped     <= res_drop_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

@@ tb/sv/fwpr_tb_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard for the priority-removal queue: predicted contents and pending results.
package fwpr_tb_pkg;
	import fwpr_pkg::*;

	typedef struct packed {
		pay_t     pay;
		logic     found;
		cnt_out_t cnt;
		logic     dropped;
	} outcome_t;

	class queue_scoreboard;
		int       size_limit;
		entry_t   held[$];
		outcome_t awaited[$];
		int       errors;
		int       n_push;
		int       n_pop;
		int       n_remove;
		int       n_drop;
		int       n_miss;
		int       n_checked;
		int       peak;

		function new(int limit);
			size_limit = limit;
		endfunction

		function void note_op(kind_t kind, pay_t pay, pri_t pri);
			outcome_t o;
			entry_t   e;
			int       best;
			int       i;
			o = '0;
			case (kind)
			KIND_PUSH: begin
				n_push++;
				if (held.size() >= size_limit) begin
					o.dropped = 1'b1;
					n_drop++;
				end else begin
					e.pri = pri;
					e.pay = pay;
					held.push_back(e);
				end
			end
			KIND_POP: begin
				n_pop++;
				if (held.size() > 0) begin
					o.pay = held[0].pay;
					o.found = 1'b1;
					held.delete(0);
				end else begin
					n_miss++;
				end
			end
			KIND_REMOVE_MAX: begin
				n_remove++;
				if (held.size() > 0) begin
					best = 0;
					for (i = 1; i < held.size(); i++) begin
						if (held[i].pri > held[best].pri)
							best = i;
					end
					o.pay = held[best].pay;
					o.found = 1'b1;
					held.delete(best);
				end else begin
					n_miss++;
				end
			end
			default: ;
			endcase
			o.cnt = cnt_out_t'(held.size());
			if (held.size() > peak)
				peak = held.size();
			awaited.push_back(o);
		endfunction

		function void check_result(pay_t pay, logic found, cnt_out_t cnt, logic dropped);
			outcome_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result: payload %h found %b count %0d dropped %b",
					$time, pay, found, cnt, dropped);
				errors++;
				return;
			end
			want = awaited.pop_front();
			n_checked++;
			if (pay !== want.pay) begin
				$display("%0t: out_payload expected %h actual %h", $time, want.pay, pay);
				errors++;
			end
			if (found !== want.found) begin
				$display("%0t: found expected %b actual %b", $time, want.found, found);
				errors++;
			end
			if (cnt !== want.cnt) begin
				$display("%0t: count expected %0d actual %0d", $time, want.cnt, cnt);
				errors++;
			end
			if (dropped !== want.dropped) begin
				$display("%0t: dropped expected %b actual %b", $time, want.dropped, dropped);
				errors++;
			end
		endfunction
	endclass

endpackage

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for fifo_with_priority_removal: directed and random operations checked by a scoreboard.
module testbench;
	import fwpr_pkg::*;
	import fwpr_tb_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int RANDOM_OPS  = 500;
	localparam int TAIL_CYCLES = 2 * DEPTH + 20;
	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_OFF    = 400;
	localparam int HOLD_AFTER  = 150;

	typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;
	typedef enum {PRI_WIDE, PRI_NARROW, PRI_EXTREME} pri_mode_t;

	logic clk;
	logic arst_n;
	fwpr_req_if req_ch ();
	fwpr_rsp_if rsp_ch ();
	queue_scoreboard board = new(DEPTH);
	int burst_left = 4;
	int results_seen = 0;

	fifo_with_priority_removal #(.DEPTH(DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic offer(input kind_t kind, input pay_t pay, input pri_t pri);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.payload <= pay;
		req_ch.priority_req <= pri;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		board.note_op(kind, pay, pri);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic pri_t directed_pri(int i);
		if (i == 2 || i == 9)
			return 8'hFF;
		if (i == DEPTH - 1)
			return 8'hFE;
		return pri_t'(i % 4);
	endfunction

	// receiver: own stall pattern, one long hold-off to back up the queue
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       phase;
		bit       held_off;
		mode = RX_OPEN;
		mode_left = 0;
		phase = 0;
		held_off = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				board.check_result(rsp_ch.out_payload, rsp_ch.found, rsp_ch.count,
					rsp_ch.dropped);
				results_seen++;
			end
			if (!held_off && results_seen >= HOLD_AFTER) begin
				held_off = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 60);
				end
				mode_left--;
				phase++;
				case (mode)
				RX_OPEN:   rsp_ch.ready <= 1'b1;
				RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 9) < 6);
				default:   rsp_ch.ready <= (phase % 4 == 0);
				endcase
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		kind_t     kind;
		pay_t      pay;
		pri_t      pri;
		pri_mode_t pri_mode;
		int        fill_pct;
		int        phase_len;
		int        sent;
		int        i;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_PUSH;
		req_ch.payload <= '0;
		req_ch.priority_req <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, then fill past full, then ties and tail maximum
		offer(KIND_POP, 16'h1234, 8'h00);
		offer(KIND_REMOVE_MAX, 16'hFFFF, 8'hFF);
		for (i = 0; i < DEPTH; i++)
			offer(KIND_PUSH, pay_t'(i * 16'h1111), directed_pri(i));
		offer(KIND_PUSH, 16'hBEEF, 8'hFF);
		offer(KIND_REMOVE_MAX, 16'h0000, 8'h00);
		offer(KIND_REMOVE_MAX, 16'h0000, 8'h00);
		offer(KIND_REMOVE_MAX, 16'h0000, 8'h00);
		offer(KIND_POP, 16'h0000, 8'h00);

		sent = 0;
		while (sent < RANDOM_OPS) begin
			phase_len = $urandom_range(8, 40);
			case ($urandom_range(0, 2))
			0:       fill_pct = 85;
			1:       fill_pct = 15;
			default: fill_pct = 50;
			endcase
			pri_mode = pri_mode_t'($urandom_range(0, 2));
			repeat (phase_len) begin
				if ($urandom_range(0, 99) < fill_pct)
					kind = KIND_PUSH;
				else
					kind = $urandom_range(0, 1) ? KIND_POP : KIND_REMOVE_MAX;
				pay = pay_t'($urandom);
				case (pri_mode)
				PRI_WIDE:   pri = pri_t'($urandom);
				PRI_NARROW: pri = pri_t'($urandom_range(0, 3));
				default:    pri = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				endcase
				offer(kind, pay, pri);
				sent++;
			end
		end
		req_ch.valid <= 1'b0;

		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d pushes (%0d into a full queue), %0d pops, %0d max removals",
			board.n_push, board.n_drop, board.n_pop, board.n_remove);
		$display("%0d removals from an empty queue, peak occupancy %0d of %0d, %0d results checked",
			board.n_miss, board.peak, DEPTH, board.n_checked);
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
